[rtl/lstw_pkg.sv]
// ----------------------------------------------------------------------------
// lstw_pkg
// shared types, constants and helper functions of the scan-to-world block
// ----------------------------------------------------------------------------
`default_nettype none

package lstw_pkg;

  localparam int MAX_BEAMS    = 2048;
  localparam int ANGLE_BITS   = 16;
  localparam int PHASE_BITS   = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int IDX_W        = 11;
  localparam int REG_IDX_W    = 3;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic [PHASE_BITS-1:0] KEEP_MASK =
    PHASE_BITS'(((1 << PHASE_BITS) - 1) & ~((1 << (PHASE_BITS - ANGLE_BITS)) - 1));
  localparam logic [PHASE_BITS-1:0] HALF_TURN = PHASE_BITS'(1 << (PHASE_BITS - 1));

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_RANGE     = 3'd0,
    REG_MAX_RANGE     = 3'd1,
    REG_FIRST_ANGLE   = 3'd2,
    REG_ANGLE_STEP    = 3'd3,
    REG_SCAN_INTERVAL = 3'd4,
    REG_REF_POSITION  = 3'd5
  } reg_idx_t;

  typedef enum logic {
    CMD_POSE   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [15:0] first_angle;
    logic [15:0] angle_step;
    logic [15:0] scan_interval;
    logic [31:0] ref_position;
  } cfg_t;

  typedef struct packed {
    cmd_t             cmd;
    logic             keep;
    logic             en;
    logic [15:0]      range;
    logic [IDX_W-1:0] idx;
    logic [31:0]      travel;
    logic [31:0]      start_x;
    logic [31:0]      start_y;
  } item_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [20:0] z;
    logic               flip;
  } cordic_t;

  function automatic logic signed [20:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [20:0] v;
    case (i)
      4'd0:    v = 21'sd131072;
      4'd1:    v = 21'sd77376;
      4'd2:    v = 21'sd40884;
      4'd3:    v = 21'sd20753;
      4'd4:    v = 21'sd10417;
      4'd5:    v = 21'sd5213;
      4'd6:    v = 21'sd2607;
      4'd7:    v = 21'sd1304;
      4'd8:    v = 21'sd652;
      4'd9:    v = 21'sd326;
      4'd10:   v = 21'sd163;
      4'd11:   v = 21'sd81;
      4'd12:   v = 21'sd41;
      4'd13:   v = 21'sd20;
      4'd14:   v = 21'sd10;
      default: v = 21'sd5;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) r = 16'sh7fff;
    else if (v < -19'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/lstw_cell.sv]
// ----------------------------------------------------------------------------
// lstw_cell
// one rotation step of the sine/cosine chain, registered, item rides along
// ----------------------------------------------------------------------------
`default_nettype none

module lstw_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         adv,
  input  wire logic [lstw_pkg::STEP_W-1:0]  step,
  input  wire logic                         v_in,
  input  wire lstw_pkg::cordic_t            c_in,
  input  wire lstw_pkg::item_t              it_in,
  output logic                              v_out,
  output lstw_pkg::cordic_t                 c_out,
  output lstw_pkg::item_t                   it_out
);

  logic              v_r;
  lstw_pkg::cordic_t c_r, c_nxt;
  lstw_pkg::item_t   it_r;

  always_comb begin
    logic signed [32:0] dx, dy;
    dx = c_in.y >>> step;
    dy = c_in.x >>> step;
    c_nxt = c_in;
    if (!c_in.z[20]) begin
      c_nxt.x = c_in.x - dx;
      c_nxt.y = c_in.y + dy;
      c_nxt.z = c_in.z - lstw_pkg::atan_val(step);
    end else begin
      c_nxt.x = c_in.x + dx;
      c_nxt.y = c_in.y - dy;
      c_nxt.z = c_in.z + lstw_pkg::atan_val(step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r  <= c_nxt;
      it_r <= it_in;
    end
  end

  assign v_out  = v_r;
  assign c_out  = c_r;
  assign it_out = it_r;

endmodule

`default_nettype wire

[rtl/lstw_cfg.sv]
// ----------------------------------------------------------------------------
// lstw_cfg
// configuration register file with index decode
// ----------------------------------------------------------------------------
`default_nettype none

module lstw_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [lstw_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic [31:0]                     wr_data,
  output lstw_pkg::cfg_t                       cfg
);

  lstw_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_range     <= 16'd20;
      cfg_r.max_range     <= 16'd60000;
      cfg_r.first_angle   <= 16'hA000;
      cfg_r.angle_step    <= 16'd46;
      cfg_r.scan_interval <= 16'd0;
      cfg_r.ref_position  <= 32'd0;
    end else if (wr_en) begin
      unique case (lstw_pkg::reg_idx_t'(wr_index))
        lstw_pkg::REG_MIN_RANGE:     cfg_r.min_range     <= wr_data[15:0];
        lstw_pkg::REG_MAX_RANGE:     cfg_r.max_range     <= wr_data[15:0];
        lstw_pkg::REG_FIRST_ANGLE:   cfg_r.first_angle   <= wr_data[15:0];
        lstw_pkg::REG_ANGLE_STEP:    cfg_r.angle_step    <= wr_data[15:0];
        lstw_pkg::REG_SCAN_INTERVAL: cfg_r.scan_interval <= wr_data[15:0];
        lstw_pkg::REG_REF_POSITION:  cfg_r.ref_position  <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/lidar_scan_to_world_points.sv]
// ----------------------------------------------------------------------------
// lidar_scan_to_world_points
// range samples to world-plane points through a pose-rotated transform
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline is not halted, and the pipeline
// holds 23 items in flight: an entry stage, a chain of 16 rotation cells for
// sine/cosine, a rounding stage, a multiply stage, a local point and pose base
// stage, a second multiply stage, an add stage and the output register. Results
// leave through the output register; pose items and dropped samples give none.
// The whole pipeline advances together and halts only while the output register
// holds a result that is stalled.
`default_nettype none

module lidar_scan_to_world_points (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_command,
  input  wire logic [15:0]                         in_range_mm,
  input  wire logic [10:0]                         in_beam_index,
  input  wire logic signed [15:0]                  in_heading,
  input  wire logic signed [31:0]                  in_position_mm,
  input  wire logic signed [31:0]                  in_travel_mm,
  input  wire logic signed [31:0]                  in_start_x_mm,
  input  wire logic signed [31:0]                  in_start_y_mm,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [31:0]                       out_point_x_mm,
  output logic signed [31:0]                       out_point_y_mm,
  output logic [10:0]                              out_point_index,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [lstw_pkg::REG_IDX_W-1:0]      cfg_index,
  input  wire logic [31:0]                         cfg_data
);

  localparam int NC = lstw_pkg::CORDIC_STEPS;

  lstw_pkg::cfg_t cfg;
  logic adv;

  assign cfg_ready = 1'b1;

  lstw_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // entry stage
  logic            ve_r;
  lstw_pkg::item_t ie_r, ie_nxt;
  logic [15:0]     ae_r, ae_nxt;

  always_comb begin
    logic [26:0]        prod;
    logic signed [32:0] diff, absd;
    prod = 27'(in_beam_index) * 27'(cfg.angle_step);
    diff = {in_position_mm[31], in_position_mm}
         - {cfg.ref_position[31], cfg.ref_position};
    absd = diff[32] ? -diff : diff;
    ie_nxt.cmd     = lstw_pkg::cmd_t'(in_command);
    ie_nxt.keep    = ({2'b00, in_beam_index} < 13'(lstw_pkg::MAX_BEAMS))
                     && (in_range_mm > cfg.min_range) && (in_range_mm < cfg.max_range);
    ie_nxt.en      = !in_position_mm[31] && (absd >= {17'd0, cfg.scan_interval});
    ie_nxt.range   = in_range_mm;
    ie_nxt.idx     = in_beam_index;
    ie_nxt.travel  = in_travel_mm;
    ie_nxt.start_x = in_start_x_mm;
    ie_nxt.start_y = in_start_y_mm;
    ae_nxt = (in_command == lstw_pkg::CMD_SAMPLE) ?
             16'(cfg.first_angle + prod[15:0]) : in_heading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (adv) begin
      ve_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ie_r <= ie_nxt;
      ae_r <= ae_nxt;
    end
  end

  // rotation chain
  logic              cv [0:NC];
  lstw_pkg::cordic_t cc [0:NC];
  lstw_pkg::item_t   ci [0:NC];

  always_comb begin
    logic [lstw_pkg::PHASE_BITS-1:0] p;
    logic                            fl;
    p  = {ae_r, 4'b0000} & lstw_pkg::KEEP_MASK;
    fl = p[lstw_pkg::PHASE_BITS-1] ^ p[lstw_pkg::PHASE_BITS-2];
    if (fl) p = p ^ lstw_pkg::HALF_TURN;
    cc[0].x    = lstw_pkg::CORDIC_X0;
    cc[0].y    = 33'sd0;
    cc[0].z    = {p[lstw_pkg::PHASE_BITS-1], p};
    cc[0].flip = fl;
  end

  assign cv[0] = ve_r;
  assign ci[0] = ie_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    lstw_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .step   ((lstw_pkg::STEP_W)'(g)),
      .v_in   (cv[g]),
      .c_in   (cc[g]),
      .it_in  (ci[g]),
      .v_out  (cv[g+1]),
      .c_out  (cc[g+1]),
      .it_out (ci[g+1])
    );
  end

  // rounding to q1.15
  logic               vq_r;
  lstw_pkg::item_t    iq_r;
  logic signed [15:0] cq_r, sq_r, cq_nxt, sq_nxt;

  always_comb begin
    logic signed [32:0] xf, yf;
    logic signed [33:0] tx, ty;
    xf = cc[NC].flip ? -cc[NC].x : cc[NC].x;
    yf = cc[NC].flip ? -cc[NC].y : cc[NC].y;
    tx = ({xf[32], xf} + 34'sd16384) >>> 15;
    ty = ({yf[32], yf} + 34'sd16384) >>> 15;
    cq_nxt = lstw_pkg::sat16(tx[18:0]);
    sq_nxt = lstw_pkg::sat16(ty[18:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else if (adv) begin
      vq_r <= cv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      iq_r <= ci[NC];
      cq_r <= cq_nxt;
      sq_r <= sq_nxt;
    end
  end

  // first multiply: pose travel or sample range
  logic               vm_r;
  lstw_pkg::item_t    im_r;
  logic signed [48:0] p1_r, p2_r;
  logic signed [15:0] cm_r, sm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= vq_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [32:0] a;
    if (adv) begin
      a = (iq_r.cmd == lstw_pkg::CMD_SAMPLE) ?
          $signed({17'd0, iq_r.range}) : $signed({iq_r.travel[31], iq_r.travel});
      p1_r <= 49'(cq_r * a);
      p2_r <= 49'(sq_r * a);
      im_r <= iq_r;
      cm_r <= cq_r;
      sm_r <= sq_r;
    end
  end

  logic signed [34:0] r1, r2;
  logic signed [31:0] bx_nxt, by_nxt;

  always_comb begin
    logic signed [49:0] t1, t2;
    t1 = ({p1_r[48], p1_r} + 50'sd16384) >>> 15;
    t2 = ({p2_r[48], p2_r} + 50'sd16384) >>> 15;
    r1 = t1[34:0];
    r2 = t2[34:0];
    bx_nxt = lstw_pkg::sat32(40'($signed(im_r.start_x)) + 40'(r1));
    by_nxt = lstw_pkg::sat32(40'($signed(im_r.start_y)) - 40'(r2));
  end

  // pose state
  logic               sen_r;
  logic signed [15:0] hc_r, hs_r;
  logic signed [31:0] bx_r, by_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sen_r <= 1'b0;
      hc_r  <= 16'sd0;
      hs_r  <= 16'sd0;
      bx_r  <= 32'sd0;
      by_r  <= 32'sd0;
    end else if (adv && vm_r && im_r.cmd == lstw_pkg::CMD_POSE) begin
      sen_r <= im_r.en;
      hc_r  <= cm_r;
      hs_r  <= sm_r;
      bx_r  <= bx_nxt;
      by_r  <= by_nxt;
    end
  end

  // local point
  logic                   vr_r;
  logic signed [17:0]     lx_r, ly_r;
  logic [lstw_pkg::IDX_W-1:0] ir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vr_r <= 1'b0;
    end else if (adv) begin
      vr_r <= vm_r && (im_r.cmd == lstw_pkg::CMD_SAMPLE) && im_r.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx_r <= r1[17:0];
      ly_r <= r2[17:0];
      ir_r <= im_r.idx;
    end
  end

  // heading rotation products
  logic                       vn_r;
  logic signed [33:0]         m1_r, m2_r, m3_r, m4_r;
  logic signed [31:0]         bxn_r, byn_r;
  logic [lstw_pkg::IDX_W-1:0] in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vn_r <= 1'b0;
    end else if (adv) begin
      vn_r <= vr_r && sen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r  <= 34'(hc_r * lx_r);
      m2_r  <= 34'(hs_r * ly_r);
      m3_r  <= 34'(hc_r * ly_r);
      m4_r  <= 34'(hs_r * lx_r);
      bxn_r <= bx_r;
      byn_r <= by_r;
      in_r  <= ir_r;
    end
  end

  // sums
  logic                       va_r;
  logic signed [34:0]         sx_r, sy_r;
  logic signed [31:0]         bxa_r, bya_r;
  logic [lstw_pkg::IDX_W-1:0] ia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= vn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= 35'(m1_r) + 35'(m2_r);
      sy_r  <= 35'(m3_r) - 35'(m4_r);
      bxa_r <= bxn_r;
      bya_r <= byn_r;
      ia_r  <= in_r;
    end
  end

  // output register
  logic                       out_valid_r;
  logic signed [31:0]         px_r, py_r, px_nxt, py_nxt;
  logic [lstw_pkg::IDX_W-1:0] pi_r;

  always_comb begin
    logic signed [35:0] tx, ty;
    tx = ({sx_r[34], sx_r} + 36'sd16384) >>> 15;
    ty = ({sy_r[34], sy_r} + 36'sd16384) >>> 15;
    px_nxt = lstw_pkg::sat32(40'($signed(bxa_r)) + 40'($signed(tx[19:0])));
    py_nxt = lstw_pkg::sat32(40'($signed(bya_r)) + 40'($signed(ty[19:0])));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && va_r) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
      pi_r <= ia_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x_mm  = px_r;
  assign out_point_y_mm  = py_r;
  assign out_point_index = pi_r;

  a_reset_disables_scan: assert property (@(posedge clk)
    !$past(rst_n) |-> !sen_r)
    else $error("scan enabled straight after reset");

  a_result_from_sum_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(va_r))
    else $error("result without a valid sum stage");

  a_frozen_entry: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(ve_r))
    else $error("entry stage moved while frozen");

  a_no_point_when_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vr_r && !sen_r |=> !vn_r)
    else $error("point passed with scan disabled");

endmodule

`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lidar_scan_to_world_points: directed table then
// random pose/sample streams, compared against a bit-exact predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int PIPE_LAT = 24;

  typedef struct {
    logic        cmd;
    logic [15:0] range;
    logic [10:0] idx;
    logic [15:0] heading;
    logic [31:0] pos;
    logic [31:0] travel;
    logic [31:0] sx;
    logic [31:0] sy;
    logic        has_fixed;
    logic [31:0] fx;
    logic [31:0] fy;
  } row_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [10:0] idx;
  } point_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic in_command = 0;
  logic [15:0] in_range_mm = 0;
  logic [10:0] in_beam_index = 0;
  logic signed [15:0] in_heading = 0;
  logic signed [31:0] in_position_mm = 0, in_travel_mm = 0, in_start_x_mm = 0,
    in_start_y_mm = 0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] out_point_x_mm, out_point_y_mm;
  logic [10:0] out_point_index;
  logic cfg_valid = 0, cfg_ready;
  logic [lstw_pkg::REG_IDX_W-1:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  lidar_scan_to_world_points u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  longint m_min, m_max, m_first, m_step, m_ivl, m_ref;
  bit     m_en;
  longint m_head, m_bx, m_by;

  point_t points_due[$];
  int     n_err = 0;
  bit     hold_long = 0;
  bit     fixed_pending = 0;
  logic [31:0] fixed_x, fixed_y;

  function automatic longint asr_l(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void trig(longint ang, output longint c, output longint s);
    longint atan_k[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                           652, 326, 163, 81, 41, 20, 10, 5};
    longint full, p, x, y, z, dx, dy;
    bit flip;
    full = 1 << 20;
    p = ((ang & 16'hffff) << 4) & longint'(lstw_pkg::KEEP_MASK);
    flip = 0;
    x = 652032874;
    y = 0;
    if (p >= (full >> 2) && p < 3 * (full >> 2)) begin
      p = p ^ (full >> 1);
      flip = 1;
    end
    z = (p >= (full >> 1)) ? p - full : p;
    for (int i = 0; i < 16; i++) begin
      dx = asr_l(y, i);
      dy = asr_l(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_k[i];
      end else begin
        x += dx; y -= dy; z += atan_k[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clamp(rnd15(x), -32768, 32767);
    s = clamp(rnd15(y), -32768, 32767);
  endfunction

  function automatic void predictor_reset();
    m_min = 20; m_max = 60000; m_first = -24576; m_step = 46; m_ivl = 0; m_ref = 0;
    m_en = 0; m_head = 0; m_bx = 0; m_by = 0;
  endfunction

  function automatic void predictor_cfg(lstw_pkg::reg_idx_t r, logic [31:0] v);
    case (r)
      lstw_pkg::REG_MIN_RANGE:     m_min = v[15:0];
      lstw_pkg::REG_MAX_RANGE:     m_max = v[15:0];
      lstw_pkg::REG_FIRST_ANGLE:   m_first = longint'($signed(v[15:0]));
      lstw_pkg::REG_ANGLE_STEP:    m_step = v[15:0];
      lstw_pkg::REG_SCAN_INTERVAL: m_ivl = v[15:0];
      lstw_pkg::REG_REF_POSITION:  m_ref = longint'($signed(v));
      default: ;
    endcase
  endfunction

  // returns 1 when the item yields a world point
  function automatic bit project_item(row_t r, output point_t pt);
    longint pos, trv, d, ch, sh, cb, sb, lx, ly, beam;
    if (r.cmd == lstw_pkg::CMD_POSE) begin
      pos = longint'($signed(r.pos));
      trv = longint'($signed(r.travel));
      d = pos - m_ref;
      if (d < 0) d = -d;
      m_head = longint'($signed(r.heading));
      m_en = (pos >= 0) && (d >= m_ivl);
      trig(m_head, ch, sh);
      m_bx = clamp(longint'($signed(r.sx)) + rnd15(ch * trv), -64'sd2147483648, 2147483647);
      m_by = clamp(longint'($signed(r.sy)) - rnd15(sh * trv), -64'sd2147483648, 2147483647);
      return 0;
    end
    if (!m_en || r.idx >= lstw_pkg::MAX_BEAMS) return 0;
    if (r.range <= m_min || r.range >= m_max) return 0;
    beam = (m_first + longint'(r.idx) * m_step) & 16'hffff;
    trig(beam, cb, sb);
    lx = rnd15(longint'(r.range) * cb);
    ly = rnd15(longint'(r.range) * sb);
    trig(m_head, ch, sh);
    pt.x = 32'(clamp(m_bx + rnd15(ch * lx + sh * ly), -64'sd2147483648, 2147483647));
    pt.y = 32'(clamp(m_by + rnd15(ch * ly - sh * lx), -64'sd2147483648, 2147483647));
    pt.idx = r.idx;
    return 1;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    n_err++;
  endtask

  // result side
  initial begin
    int w;
    point_t e;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          report("unexpected point", 32'(out_point_index), 32'd0);
        end else begin
          e = points_due.pop_front();
          if (out_point_x_mm !== e.x) report("point_x", out_point_x_mm, e.x);
          if (out_point_y_mm !== e.y) report("point_y", out_point_y_mm, e.y);
          if (out_point_index !== e.idx)
            report("point_index", 32'(out_point_index), 32'(e.idx));
        end
      end
      if (hold_long) begin
        out_stall <= 1;
        repeat (60) @(posedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (w != 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  task automatic send(row_t r);
    point_t pt;
    int gap;
    in_valid <= 1;
    in_command <= r.cmd;
    in_range_mm <= r.range;
    in_beam_index <= r.idx;
    in_heading <= r.heading;
    in_position_mm <= r.pos;
    in_travel_mm <= r.travel;
    in_start_x_mm <= r.sx;
    in_start_y_mm <= r.sy;
    do @(posedge clk); while (in_stall);
    if (project_item(r, pt)) begin
      if (r.has_fixed) begin
        pt.x = r.fx;
        pt.y = r.fy;
      end
      points_due.push_back(pt);
    end
    gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(lstw_pkg::reg_idx_t r, logic [31:0] v);
    cfg_valid <= 1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    predictor_cfg(r, v);
    @(posedge clk);
  endtask

  function automatic row_t pose(logic [15:0] h, logic [31:0] p, logic [31:0] t,
                                logic [31:0] x, logic [31:0] y);
    row_t r;
    r = '{lstw_pkg::CMD_POSE, 16'($urandom), 11'($urandom), h, p, t, x, y, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t sample(logic [15:0] rg, logic [10:0] i);
    row_t r;
    r = '{lstw_pkg::CMD_SAMPLE, rg, i, 16'($urandom), $urandom, $urandom, $urandom,
          $urandom, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t random_pose();
    return pose(16'($urandom),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000),
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 4000) - 2000,
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000,
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2000000) - 1000000);
  endfunction

  initial begin
    row_t dir[$];
    row_t r;
    int n_rand;
    predictor_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // sample before any pose: dropped
    dir.push_back(sample(1000, 0));
    // zero pose, heading 0: point is range along beam at first_angle
    dir.push_back(pose(0, 0, 0, 0, 0));
    r = sample(1000, 0); dir.push_back(r);
    dir.push_back(sample(20, 5));          // at min range
    dir.push_back(sample(21, 6));
    dir.push_back(sample(60000, 7));       // at max range
    dir.push_back(sample(59999, 2047));
    dir.push_back(sample(16'hffff, 100));
    dir.push_back(sample(0, 101));
    // negative position disables the scan
    dir.push_back(pose(16'h4000, 32'h80000000, 0, 0, 0));
    dir.push_back(sample(5000, 3));
    // saturation at the extremes of start
    dir.push_back(pose(0, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000));
    r = sample(59999, 512); r.has_fixed = 1; r.fx = 32'h7fffffff; r.fy = 32'h80000000;
    dir.push_back(r);
    dir.push_back(pose(16'h8000, 100, 32'h80000000, 32'h80000000, 32'h7fffffff));
    dir.push_back(sample(1234, 1024));
    dir.push_back(pose(16'h7fff, 5, 1000, 12, -34));
    dir.push_back(sample(777, 1500));
    dir.push_back(pose(16'hc000, 0, -1000, 0, 0));
    dir.push_back(sample(40000, 2047));
    foreach (dir[i]) send(dir[i]);
    drain();

    // gating with interval and reference, angle wrap
    write_reg(lstw_pkg::REG_SCAN_INTERVAL, 16'hffff);
    write_reg(lstw_pkg::REG_REF_POSITION, 32'h7fff0000);
    write_reg(lstw_pkg::REG_FIRST_ANGLE, 16'h7fff);
    write_reg(lstw_pkg::REG_ANGLE_STEP, 16'hffff);
    send(pose(0, 32'h7fffffff, 0, 0, 0));
    send(sample(3000, 2047));
    send(pose(0, 32'h7ffe0001, 0, 0, 0));
    send(sample(3000, 2047));
    send(pose(0, 0, 0, 0, 0));
    send(sample(3000, 2));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(lstw_pkg::REG_MIN_RANGE, 0);
          write_reg(lstw_pkg::REG_MAX_RANGE, 16'hffff);
          write_reg(lstw_pkg::REG_SCAN_INTERVAL, 0);
          write_reg(lstw_pkg::REG_REF_POSITION, 0);
          write_reg(lstw_pkg::REG_FIRST_ANGLE, 16'h8000);
          write_reg(lstw_pkg::REG_ANGLE_STEP, 0);
        end
        1: begin
          write_reg(lstw_pkg::REG_ANGLE_STEP, $urandom);
          write_reg(lstw_pkg::REG_FIRST_ANGLE, $urandom);
          write_reg(lstw_pkg::REG_MIN_RANGE, $urandom_range(0, 3000));
          write_reg(lstw_pkg::REG_MAX_RANGE, $urandom_range(30000, 65535));
        end
        2: begin
          write_reg(lstw_pkg::REG_MIN_RANGE, 16'hffff);
          write_reg(lstw_pkg::REG_MAX_RANGE, 0);
        end
        3: begin
          write_reg(lstw_pkg::REG_MIN_RANGE, 20);
          write_reg(lstw_pkg::REG_MAX_RANGE, 60000);
          write_reg(lstw_pkg::REG_FIRST_ANGLE, -24576);
          write_reg(lstw_pkg::REG_ANGLE_STEP, 46);
          write_reg(lstw_pkg::REG_SCAN_INTERVAL, $urandom_range(0, 50000));
          write_reg(lstw_pkg::REG_REF_POSITION, $urandom_range(0, 100000));
        end
        default: begin
          write_reg(lstw_pkg::REG_SCAN_INTERVAL, 0);
          write_reg(lstw_pkg::REG_REF_POSITION, 32'h80000000);
          write_reg(lstw_pkg::REG_ANGLE_STEP, $urandom_range(0, 64));
        end
      endcase
      n_rand = (ph == 2) ? 50 : 300;
      if (ph == 1) hold_long = 1;
      for (int k = 0; k < n_rand; k++) begin
        if (k % 40 == 0 || $urandom_range(0, 30) == 0) begin
          send(random_pose());
        end else if ($urandom_range(0, 15) == 0) begin
          send(sample(16'($urandom), 11'($urandom)));
        end else begin
          send(sample(16'($urandom_range(0, 65535)), 11'($urandom_range(0, 2047))));
        end
        if (k == 150) begin
          in_valid <= 0;
          do @(posedge clk); while (points_due.size() != 0);
        end
      end
      drain();
    end

    if (n_err == 0) begin
      $display("lidar_scan_to_world_points verification clean");
    end else begin
      $display("lidar_scan_to_world_points verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("lidar_scan_to_world_points verification failed");
    $finish;
  end

endmodule

`default_nettype wire
